/* hw/rtl/rlbsc_pkg.sv */
`timescale 1ns / 1ps

package rlbsc_pkg;

  localparam int MaxOnes  = 1023;
  localparam int MaxZeros = 1023;
  localparam int CntW     = 10;
  localparam int AddrW    = $clog2(MaxOnes + 1);
  localparam int Depth    = MaxOnes + 1;
  localparam int ValW     = 30;
  localparam logic [ValW-1:0] PrimeMod = ValW'(1000000007);

  typedef struct packed {
    logic load;
    logic init_en;
    logic sweep_start;
    logic fetch;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic busy;
    logic zeros_done;
    logic no_sweep;
    logic out_free;
  } dp_stat_t;

  function automatic logic [ValW-1:0] add_mod(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PrimeMod}) begin
      s = s - {1'b0, PrimeMod};
    end
    return s[ValW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] sat_ones(input logic [CntW-1:0] v);
    if (int'(v) > MaxOnes) begin
      return AddrW'(MaxOnes);
    end
    return AddrW'(v);
  endfunction

  function automatic logic [CntW-1:0] sat_zeros(input logic [CntW-1:0] v);
    if (int'(v) > MaxZeros) begin
      return CntW'(MaxZeros);
    end
    return v;
  endfunction

endpackage

/* hw/rtl/rlbsc_ctrl.sv */
`timescale 1ns / 1ps

module rlbsc_ctrl import rlbsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StInit    = 6'b000010,
    StSwStart = 6'b000100,
    StSwWait  = 6'b001000,
    StFetch   = 6'b010000,
    StCapture = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        cmd_o.init_en = 1'b1;
        if (stat_i.init_last) begin
          state_d = stat_i.no_sweep ? StFetch : StSwStart;
        end
      end
      StSwStart: begin
        cmd_o.sweep_start = 1'b1;
        state_d           = StSwWait;
      end
      StSwWait: begin
        if (!stat_i.busy) begin
          state_d = stat_i.zeros_done ? StFetch : StSwStart;
        end
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = StCapture;
      end
      StCapture: begin
        if (stat_i.out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/rlbsc_datapath.sv */
`timescale 1ns / 1ps

module rlbsc_datapath import rlbsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_stat_t         stat_o,
  input  logic             op_i,
  input  logic [CntW-1:0]  zeros_count_i,
  input  logic [CntW-1:0]  ones_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  string_count_o
);

  logic [ValW-1:0]  row_mem [Depth];
  logic [ValW-1:0]  rdata_q;

  logic             op_q;
  logic [CntW-1:0]  zeros_q;
  logic [AddrW-1:0] ones_q;
  logic [CntW-1:0]  zi_q;
  logic [AddrW-1:0] init_ptr_q;

  logic             iss_active_q, iss_virt_q;
  logic [AddrW-1:0] iss_ptr_q;
  logic             s1_valid_q, s1_virt_q;
  logic [ValW-1:0]  win_hi_q, win_mid_q, win_lo_q;
  logic [1:0]       win_cnt_q;
  logic             win_valid_q;
  logic             a_valid_q;
  logic [ValW-1:0]  a_sum_q, a_c_q;
  logic [AddrW-1:0] a_addr_q, wj_q;

  logic             out_valid_q;
  logic [ValW-1:0]  out_data_q;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ValW-1:0]  mem_wdata, init_val, arrive;

  always_comb begin
    init_val = '0;
    if (init_ptr_q <= AddrW'(1) || (init_ptr_q == AddrW'(2) && op_q)) begin
      init_val = ValW'(1);
    end
  end

  assign mem_we    = cmd_i.init_en || a_valid_q;
  assign mem_waddr = cmd_i.init_en ? init_ptr_q : a_addr_q;
  assign mem_wdata = cmd_i.init_en ? init_val : add_mod(a_sum_q, a_c_q);
  assign mem_re    = cmd_i.fetch || (iss_active_q && !iss_virt_q);
  assign mem_raddr = cmd_i.fetch ? ones_q : iss_ptr_q;
  assign arrive    = s1_virt_q ? '0 : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= row_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      zeros_q <= sat_zeros(zeros_count_i);
      ones_q  <= sat_ones(ones_count_i);
    end
    if (cmd_i.sweep_start) begin
      iss_ptr_q <= ones_q;
    end else if (iss_active_q && !iss_virt_q && iss_ptr_q != '0) begin
      iss_ptr_q <= iss_ptr_q - AddrW'(1);
    end
    s1_virt_q <= iss_virt_q;
    if (s1_valid_q) begin
      win_hi_q  <= win_mid_q;
      win_mid_q <= win_lo_q;
      win_lo_q  <= arrive;
    end
    if (win_valid_q) begin
      a_sum_q  <= add_mod(win_hi_q, win_mid_q);
      a_c_q    <= op_q ? win_lo_q : '0;
      a_addr_q <= wj_q;
    end
    if (cmd_i.sweep_start) begin
      wj_q <= ones_q;
    end else if (win_valid_q) begin
      wj_q <= wj_q - AddrW'(1);
    end
    if (cmd_i.capture) begin
      out_data_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zi_q         <= '0;
      init_ptr_q   <= '0;
      iss_active_q <= 1'b0;
      iss_virt_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      win_cnt_q    <= '0;
      win_valid_q  <= 1'b0;
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        zi_q       <= '0;
        init_ptr_q <= '0;
      end else begin
        if (cmd_i.sweep_start) begin
          zi_q <= zi_q + CntW'(1);
        end
        if (cmd_i.init_en) begin
          init_ptr_q <= init_ptr_q + AddrW'(1);
        end
      end
      if (cmd_i.sweep_start) begin
        iss_active_q <= 1'b1;
        iss_virt_q   <= 1'b0;
      end else if (iss_active_q) begin
        if (iss_virt_q) begin
          iss_active_q <= 1'b0;
          iss_virt_q   <= 1'b0;
        end else if (iss_ptr_q == '0) begin
          iss_virt_q <= 1'b1;
        end
      end
      s1_valid_q <= iss_active_q;
      if (cmd_i.sweep_start) begin
        win_cnt_q <= '0;
      end else if (s1_valid_q && win_cnt_q != 2'd3) begin
        win_cnt_q <= win_cnt_q + 2'd1;
      end
      win_valid_q <= s1_valid_q && (win_cnt_q >= 2'd2);
      a_valid_q   <= win_valid_q;
      if (cmd_i.capture) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.init_last  = (init_ptr_q == ones_q);
  assign stat_o.busy       = iss_active_q || s1_valid_q || win_valid_q || a_valid_q;
  assign stat_o.zeros_done = (zi_q == zeros_q);
  assign stat_o.no_sweep   = (zeros_q == '0) || (ones_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign string_count_o = out_data_q;

  // The lowest entry never changes during a sweep, and nothing above the query's count is touched.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_addr_q != '0) && (a_addr_q <= ones_q))
    else $error("sweep write outside the active row");

  a_window_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_q |-> (win_cnt_q == 2'd3))
    else $error("update issued before the window held three entries");

  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while an item waits");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep_start || cmd_i.fetch) |-> !stat_o.busy)
    else $error("new pass started while the previous one was in flight");

endmodule

/* hw/rtl/run_limited_binary_string_count_core.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// input    | in_valid_i / in_ready_o   | op_i, zeros_count_i[9:0], ones_count_i[9:0]
// output   | out_valid_o / out_ready_i | string_count_o[29:0]
//
// A query initialises the single row memory, then runs one sweep per zero, reading every entry
// once and writing every entry but the lowest once; when ones or zeros is zero, no sweep is run.
// Queries are handled one at a time; ready is high only while no query is in progress.
// A finished result waits in an output register, so the next item may be taken meanwhile.
// Reset is asynchronous and active low; the row memory needs no clearing after reset.

module run_limited_binary_string_count_core import rlbsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [CntW-1:0]  zeros_count_i,
  input  logic [CntW-1:0]  ones_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  string_count_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rlbsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rlbsc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .zeros_count_i  (zeros_count_i),
    .ones_count_i   (ones_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .string_count_o (string_count_o)
  );

endmodule

/* tb/sv/tb_run_limited_binary_string_count_core.sv */
`timescale 1ns / 1ps

module tb_run_limited_binary_string_count_core;
  import rlbsc_pkg::*;

  localparam logic OpNoPair   = 1'b0;
  localparam logic OpNoTriple = 1'b1;
  localparam int   NumDirected = 24;
  localparam int   NumRandom   = 76;
  localparam int   StallLimit  = 200000;

  typedef struct packed {
    logic            op;
    logic [CntW-1:0] zeros;
    logic [CntW-1:0] ones;
    logic            typed;
    logic [ValW-1:0] count;
  } query_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic            op_i;
  logic [CntW-1:0] zeros_count_i;
  logic [CntW-1:0] ones_count_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [ValW-1:0] string_count_o;

  logic [ValW-1:0] row_mem [MaxOnes+1];
  int unsigned     zero_idx;
  int unsigned     one_idx;

  logic [ValW-1:0] expected_counts [$];
  query_row_t      directed_rows [NumDirected];
  bit              calm;
  int              mismatches;
  int              queries_sent;
  int              triple_queries;
  int              results_seen;
  int              idle_cycles;

  run_limited_binary_string_count_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .zeros_count_i  (zeros_count_i),
    .ones_count_i   (ones_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .string_count_o (string_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ValW-1:0] count_strings(input logic op,
                                                    input logic [CntW-1:0] zeros,
                                                    input logic [CntW-1:0] ones);
    int              z;
    int              o;
    longint unsigned v;
    z = int'(zeros);
    o = int'(ones);
    if (z > MaxZeros) begin
      z = MaxZeros;
    end
    if (o > MaxOnes) begin
      o = MaxOnes;
    end
    for (int j = 0; j <= o; j++) begin
      row_mem[j] = (j <= 1 || (j == 2 && op == OpNoTriple)) ? ValW'(1) : ValW'(0);
    end
    for (int i = 1; i <= z; i++) begin
      for (int j = o; j >= 1; j--) begin
        v = longint'(row_mem[j]) + longint'(row_mem[j-1]);
        if (v >= PrimeMod) begin
          v -= PrimeMod;
        end
        if (op == OpNoTriple && j >= 2) begin
          v += row_mem[j-2];
          if (v >= PrimeMod) begin
            v -= PrimeMod;
          end
        end
        row_mem[j] = ValW'(v);
      end
    end
    zero_idx = z;
    one_idx  = o;
    return row_mem[o];
  endfunction

  task automatic send_query(input logic op, input logic [CntW-1:0] zeros,
                            input logic [CntW-1:0] ones, input logic typed,
                            input logic [ValW-1:0] typed_count);
    logic [ValW-1:0] want;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    zeros_count_i <= zeros;
    ones_count_i  <= ones;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    want = count_strings(op, zeros, ones);
    if (typed) begin
      want = typed_count;
    end
    expected_counts.push_back(want);
    queries_sent++;
    if (op == OpNoTriple) begin
      triple_queries++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    logic [ValW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result %0d with no query pending.", string_count_o);
        end
        mismatches++;
      end else begin
        want = expected_counts.pop_front();
        results_seen++;
        if (string_count_o !== want) begin
          if (mismatches < 10) begin
            $display("Wrong string count: expected %0d, got %0d.", want, string_count_o);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[run_limited_binary_string_count_core] ERROR");
      $finish;
    end
  end

  initial begin
    int              sel;
    logic            op;
    logic [CntW-1:0] zeros;
    logic [CntW-1:0] ones;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = 1'b0;
    zeros_count_i  = '0;
    ones_count_i   = '0;
    out_ready_i    = 1'b0;
    calm           = 1'b0;
    mismatches     = 0;
    queries_sent   = 0;
    triple_queries = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    zero_idx       = 0;
    one_idx        = 0;

    directed_rows = '{
      '{OpNoPair,   10'd0,    10'd0,    1'b1, 30'd1},
      '{OpNoTriple, 10'd0,    10'd0,    1'b1, 30'd1},
      '{OpNoPair,   10'd0,    10'd1,    1'b1, 30'd1},
      '{OpNoPair,   10'd0,    10'd2,    1'b1, 30'd0},
      '{OpNoTriple, 10'd0,    10'd2,    1'b1, 30'd1},
      '{OpNoTriple, 10'd0,    10'd3,    1'b1, 30'd0},
      '{OpNoPair,   10'd0,    10'd1023, 1'b1, 30'd0},
      '{OpNoTriple, 10'd0,    10'd1023, 1'b1, 30'd0},
      '{OpNoPair,   10'd1023, 10'd0,    1'b1, 30'd1},
      '{OpNoTriple, 10'd1023, 10'd0,    1'b1, 30'd1},
      '{OpNoTriple, 10'd1023, 10'd1,    1'b1, 30'd1024},
      '{OpNoTriple, 10'd7,    10'd1,    1'b1, 30'd8},
      '{OpNoPair,   10'd1023, 10'd1,    1'b0, 30'd0},
      '{OpNoPair,   10'd1023, 10'd2,    1'b0, 30'd0},
      '{OpNoTriple, 10'd1023, 10'd2,    1'b0, 30'd0},
      '{OpNoPair,   10'd1,    10'd1023, 1'b0, 30'd0},
      '{OpNoTriple, 10'd1,    10'd1023, 1'b0, 30'd0},
      '{OpNoTriple, 10'd3,    10'd1023, 1'b0, 30'd0},
      '{OpNoPair,   10'd5,    10'd5,    1'b0, 30'd0},
      '{OpNoTriple, 10'd5,    10'd5,    1'b0, 30'd0},
      '{OpNoPair,   10'd1023, 10'd31,   1'b0, 30'd0},
      '{OpNoTriple, 10'd1023, 10'd24,   1'b0, 30'd0},
      '{OpNoTriple, 10'd10,   10'd20,   1'b0, 30'd0},
      '{OpNoPair,   10'd20,   10'd21,   1'b0, 30'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumDirected; k++) begin
      send_query(directed_rows[k].op, directed_rows[k].zeros, directed_rows[k].ones,
                 directed_rows[k].typed, directed_rows[k].count);
    end

    // Let every outstanding result drain before the random queries start.
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);

    // Mostly small tables, with a few queries that stretch one count to its limit.
    for (int k = 0; k < NumRandom; k++) begin
      calm = (k >= 30 && k < 60);
      if (k == 75) begin
        in_valid_i <= 1'b0;
        while (expected_counts.size() != 0) begin
          @(posedge clk_i);
        end
        @(posedge clk_i);
      end
      sel = $urandom_range(99);
      op  = 1'($urandom_range(1));
      if (sel < 80) begin
        zeros = CntW'($urandom_range(31));
        ones  = CntW'($urandom_range(31));
      end else if (sel < 90) begin
        zeros = CntW'($urandom_range(1023));
        ones  = CntW'($urandom_range(15));
      end else begin
        zeros = CntW'($urandom_range(7));
        ones  = CntW'($urandom_range(1023));
      end
      send_query(op, zeros, ones, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_counts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (expected_counts.size() != 0) begin
      mismatches += expected_counts.size();
    end
    $display("Sent %0d queries (%0d limiting runs to two ones), checked %0d string counts.",
             queries_sent, triple_queries, results_seen);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("[run_limited_binary_string_count_core] OK");
    end else begin
      $display("[run_limited_binary_string_count_core] ERROR");
    end
    $finish;
  end

endmodule

/* run_limited_binary_string_count_core.f */
hw/rtl/rlbsc_pkg.sv
hw/rtl/rlbsc_ctrl.sv
hw/rtl/rlbsc_datapath.sv
hw/rtl/run_limited_binary_string_count_core.sv
tb/sv/tb_run_limited_binary_string_count_core.sv
